// ===== design/complex_arithmetic_unit_macros.svh =====
// assertion helpers
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("assertion failed");
`define CAU_ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (b)) else $error("assertion failed");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== design/cau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int QW = PW + FB + 1;
  localparam int VW = QW + 1;
  localparam int NCELL = QW;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef struct packed {
    logic [PW-1:0] rem;
    logic [QW-1:0] dq;
    logic          neg;
  } part_t;

  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          dz;
    logic [PW-1:0] den;
    part_t         re;
    part_t         im;
  } cell_t;

  typedef struct packed {
    logic [DW-1:0] res_re;
    logic [DW-1:0] res_im;
    logic          dz;
    logic          ovf;
  } result_t;

  function automatic logic signed [PW-1:0] sx(input logic signed [DW-1:0] a);
    return PW'(a);
  endfunction
endpackage
`default_nettype wire

// ===== design/cau_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cau_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [cau_pkg::DW-1:0]   first_real;
  logic signed [cau_pkg::DW-1:0]   first_imag;
  logic signed [cau_pkg::DW-1:0]   second_real;
  logic signed [cau_pkg::DW-1:0]   second_imag;
  modport source (output valid, action, first_real, first_imag, second_real, second_imag,
                  input ready);
  modport sink (input valid, action, first_real, first_imag, second_real, second_imag,
                output ready);
endinterface

interface cau_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cau_pkg::DW-1:0]   result_real;
  logic signed [cau_pkg::DW-1:0]   result_imag;
  logic                            divide_by_zero;
  logic                            overflow;
  modport source (output valid, result_real, result_imag, divide_by_zero, overflow,
                  input ready);
  modport sink (input valid, result_real, result_imag, divide_by_zero, overflow,
                output ready);
endinterface
`default_nettype wire

// ===== design/complex_arithmetic_unit.sv =====
// channel   dir   payload
// in_ch     in    action, first_real, first_imag, second_real, second_imag
// out_ch    out   result_real, result_imag, divide_by_zero, overflow
//
// One transaction per cycle sustained while the output is not stalled (Q16.16: DW = 32, FB = 16).
// The divider chain computes one restoring quotient bit per cell, over
// PW + FB + 1 cells, shared by the real and imaginary quotients.
// rst clears only the valid bits of the pipeline; in_ch.ready is low during rst.
// A stalled output freezes every stage; in_ch.ready is high while the output is empty or out_ch.ready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit (
  input wire logic  clk,
  input wire logic  rst,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);
  logic             advance;
  cau_pkg::cell_t   chain [cau_pkg::NCELL+1];
  cau_pkg::result_t result;
  logic             out_valid;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance && !rst;

  cau_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_ch.valid),
    .action   (in_ch.action),
    .xr       (in_ch.first_real),
    .xi       (in_ch.first_imag),
    .yr       (in_ch.second_real),
    .yi       (in_ch.second_imag),
    .cell_out (chain[0])
  );

  for (genvar k = 0; k < cau_pkg::NCELL; k++) begin : g_cell
    cau_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  cau_final u_final (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cell_in   (chain[cau_pkg::NCELL]),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.result_real    = result.res_re;
  assign out_ch.result_imag    = result.res_im;
  assign out_ch.divide_by_zero = result.dz;
  assign out_ch.overflow       = result.ovf;

  `CAU_ASSERT(a_dz_zero, out_valid && result.dz |-> result.res_re == '0 && result.res_im == '0 && !result.ovf)
  `CAU_ASSERT(a_ovf_sat, out_valid && result.ovf |-> result.res_re[cau_pkg::DW-2:0] == {(cau_pkg::DW-1){!result.res_re[cau_pkg::DW-1]}} || result.res_im[cau_pkg::DW-2:0] == {(cau_pkg::DW-1){!result.res_im[cau_pkg::DW-1]}})
  `CAU_ASSERT_NEXT(a_hold, out_valid && !out_ch.ready, out_valid && $stable(result))
endmodule
`default_nettype wire

// ===== design/cau_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cau_prep (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          in_valid,
  input  wire logic [1:0]                    action,
  input  wire logic signed [cau_pkg::DW-1:0] xr,
  input  wire logic signed [cau_pkg::DW-1:0] xi,
  input  wire logic signed [cau_pkg::DW-1:0] yr,
  input  wire logic signed [cau_pkg::DW-1:0] yi,
  output cau_pkg::cell_t                     cell_out
);
  logic                              v1;
  cau_pkg::action_t                  act1;
  logic signed [cau_pkg::PW-1:0]     p_rr, p_ii, p_ri, p_ir, d_r, d_i;
  logic signed [cau_pkg::DW:0]       as_re, as_im;

  logic signed [cau_pkg::SW-1:0]     num_re, num_im, mul_re, mul_im;
  logic [cau_pkg::SW-1:0]            mag_re, mag_im;
  cau_pkg::cell_t                    cell_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      act1  <= cau_pkg::action_t'(action);
      p_rr  <= cau_pkg::sx(xr) * cau_pkg::sx(yr);
      p_ii  <= cau_pkg::sx(xi) * cau_pkg::sx(yi);
      p_ri  <= cau_pkg::sx(xr) * cau_pkg::sx(yi);
      p_ir  <= cau_pkg::sx(xi) * cau_pkg::sx(yr);
      d_r   <= cau_pkg::sx(yr) * cau_pkg::sx(yr);
      d_i   <= cau_pkg::sx(yi) * cau_pkg::sx(yi);
      if (action == cau_pkg::ACT_SUB) begin
        as_re <= (cau_pkg::DW+1)'(xr) - (cau_pkg::DW+1)'(yr);
        as_im <= (cau_pkg::DW+1)'(xi) - (cau_pkg::DW+1)'(yi);
      end else begin
        as_re <= (cau_pkg::DW+1)'(xr) + (cau_pkg::DW+1)'(yr);
        as_im <= (cau_pkg::DW+1)'(xi) + (cau_pkg::DW+1)'(yi);
      end
    end
  end

  always_comb begin
    num_re = cau_pkg::SW'(p_rr) + cau_pkg::SW'(p_ii);
    num_im = cau_pkg::SW'(p_ir) - cau_pkg::SW'(p_ri);
    mul_re = (cau_pkg::SW'(p_rr) - cau_pkg::SW'(p_ii)) >>> cau_pkg::FB;
    mul_im = (cau_pkg::SW'(p_ri) + cau_pkg::SW'(p_ir)) >>> cau_pkg::FB;
    mag_re = num_re[cau_pkg::SW-1] ? cau_pkg::SW'(-num_re) : cau_pkg::SW'(num_re);
    mag_im = num_im[cau_pkg::SW-1] ? cau_pkg::SW'(-num_im) : cau_pkg::SW'(num_im);

    cell_next        = '0;
    cell_next.valid  = v1;
    cell_next.den    = cau_pkg::PW'(d_r) + cau_pkg::PW'(d_i);
    case (act1)
      cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
        cell_next.re.dq = cau_pkg::QW'(as_re);
        cell_next.im.dq = cau_pkg::QW'(as_im);
      end
      cau_pkg::ACT_MUL: begin
        cell_next.re.dq = cau_pkg::QW'(mul_re);
        cell_next.im.dq = cau_pkg::QW'(mul_im);
      end
      cau_pkg::ACT_DIV: begin
        cell_next.is_div = 1'b1;
        cell_next.dz     = (cell_next.den == '0);
        cell_next.re.neg = num_re[cau_pkg::SW-1];
        cell_next.im.neg = num_im[cau_pkg::SW-1];
        cell_next.re.dq  = cau_pkg::QW'(mag_re[cau_pkg::PW-1:0]) << cau_pkg::FB;
        cell_next.im.dq  = cau_pkg::QW'(mag_im[cau_pkg::PW-1:0]) << cau_pkg::FB;
      end
      default: begin
        cell_next.re.dq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out.valid <= cell_next.valid;
    end
    if (advance) begin
      cell_out.is_div <= cell_next.is_div;
      cell_out.dz     <= cell_next.dz;
      cell_out.den    <= cell_next.den;
      cell_out.re     <= cell_next.re;
      cell_out.im     <= cell_next.im;
    end
  end
endmodule
`default_nettype wire

// ===== design/cau_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cau_cell (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      advance,
  input  cau_pkg::cell_t cell_in,
  output cau_pkg::cell_t cell_out
);
  function automatic cau_pkg::part_t step(input cau_pkg::part_t p,
                                          input logic [cau_pkg::PW-1:0] den);
    logic [cau_pkg::PW:0] t;
    logic                 bit_q;
    cau_pkg::part_t       r;
    t     = {p.rem, p.dq[cau_pkg::QW-1]};
    bit_q = (t >= {1'b0, den});
    r     = p;
    r.rem = bit_q ? cau_pkg::PW'(t - {1'b0, den}) : t[cau_pkg::PW-1:0];
    r.dq  = {p.dq[cau_pkg::QW-2:0], bit_q};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out.valid <= cell_in.valid;
    end
    if (advance) begin
      cell_out.is_div <= cell_in.is_div;
      cell_out.dz     <= cell_in.dz;
      cell_out.den    <= cell_in.den;
      if (cell_in.is_div) begin
        cell_out.re <= step(cell_in.re, cell_in.den);
        cell_out.im <= step(cell_in.im, cell_in.den);
      end else begin
        cell_out.re <= cell_in.re;
        cell_out.im <= cell_in.im;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/cau_final.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cau_final (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  cau_pkg::cell_t  cell_in,
  output logic            out_valid,
  output cau_pkg::result_t result
);
  logic signed [cau_pkg::VW-1:0] v_re, v_im;
  logic [cau_pkg::DW-1:0]        s_re, s_im;
  logic                          o_re, o_im;
  cau_pkg::result_t              result_next;

  function automatic logic signed [cau_pkg::VW-1:0] value(input cau_pkg::part_t p,
                                                          input logic is_div);
    logic signed [cau_pkg::VW-1:0] m;
    m = {1'b0, p.dq};
    if (is_div) begin
      return p.neg ? -m : m;
    end
    return cau_pkg::VW'($signed(p.dq));
  endfunction

  function automatic logic [cau_pkg::DW:0] sat(input logic signed [cau_pkg::VW-1:0] v);
    logic [cau_pkg::VW-cau_pkg::DW:0] top;
    top = v[cau_pkg::VW-1:cau_pkg::DW-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[cau_pkg::DW-1:0]};
    end
    return v[cau_pkg::VW-1] ? {2'b11, {(cau_pkg::DW-1){1'b0}}}
                            : {2'b10, {(cau_pkg::DW-1){1'b1}}};
  endfunction

  always_comb begin
    v_re          = value(cell_in.re, cell_in.is_div);
    v_im          = value(cell_in.im, cell_in.is_div);
    {o_re, s_re}  = sat(v_re);
    {o_im, s_im}  = sat(v_im);
    result_next   = '0;
    if (cell_in.is_div && cell_in.dz) begin
      result_next.dz = 1'b1;
    end else begin
      result_next.res_re = s_re;
      result_next.res_im = s_im;
      result_next.ovf    = o_re | o_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cell_in.valid;
    end
    if (advance) begin
      result <= result_next;
    end
  end
endmodule
`default_nettype wire
